FILE: rtl/vertex_bounding_box_assert.svh
// Assertion macros used by the vertex bounding box top level.
`ifndef VERTEX_BOUNDING_BOX_ASSERT_SVH
`define VERTEX_BOUNDING_BOX_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define VBB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define VBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/vbb_pkg.sv
// Types, constants and helpers for the vertex bounding box block.
package vbb_pkg;

  // Fixed-point formats: coordinates Q12.12, coefficients Q4.12.
  localparam int CoordBits = 24;
  localparam int CoefBits  = 16;
  localparam int CoefFrac  = 12;
  localparam int RowBits   = 3 * CoefBits;
  localparam int HalfBits  = CoordBits - 1;

  // Intermediate widths of the transform.
  localparam int ProdBits = CoordBits + CoefBits;
  localparam int AccBits  = ProdBits + 2;
  localparam int RndBits  = AccBits - CoefFrac;
  localparam int SatBits  = RndBits + 2;

  // Configuration port.
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = RowBits;

  localparam logic [CfgIdxBits-1:0] CfgMode  = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgRow0  = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgRow1  = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgRow2  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgOffX  = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgOffY  = 3'd5;
  localparam logic [CfgIdxBits-1:0] CfgOffZ  = 3'd6;

  // Box modes.
  localparam logic ModeAxisAligned = 1'b0;
  localparam logic ModeOriented    = 1'b1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [CoefBits-1:0]  coef_t;
  typedef logic        [RowBits-1:0]   row_t;
  typedef logic signed [SatBits-1:0]   wide_t;

  localparam coord_t CoordMax = {1'b0, {(CoordBits-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordBits-1){1'b0}}};

  // Identity matrix rows after reset.
  localparam row_t RowReset0 = 48'h0000_0000_1000;
  localparam row_t RowReset1 = 48'h0000_1000_0000;
  localparam row_t RowReset2 = 48'h1000_0000_0000;

  // One input vertex.
  typedef struct packed {
    logic signed [CoordBits-1:0] vertex_x;
    logic signed [CoordBits-1:0] vertex_y;
    logic signed [CoordBits-1:0] vertex_z;
    logic                        last_vertex;
  } in_t;

  // One finished box.
  typedef struct packed {
    logic signed [CoordBits-1:0] min_x;
    logic signed [CoordBits-1:0] min_y;
    logic signed [CoordBits-1:0] min_z;
    logic signed [CoordBits-1:0] max_x;
    logic signed [CoordBits-1:0] max_y;
    logic signed [CoordBits-1:0] max_z;
    logic signed [CoordBits-1:0] center_x;
    logic signed [CoordBits-1:0] center_y;
    logic signed [CoordBits-1:0] center_z;
    logic        [HalfBits-1:0]  half_x;
    logic        [HalfBits-1:0]  half_y;
    logic        [HalfBits-1:0]  half_z;
  } out_t;

  // Load enables of the transform stages.
  typedef struct packed {
    logic prod_en;
    logic xform_en;
  } pipe_ctrl_t;

  // Clamp a wide signed value to the coordinate range.
  function automatic coord_t sat_coord(input wide_t v);
    coord_t res;
    if (v > wide_t'(CoordMax)) begin
      res = CoordMax;
    end else if (v < wide_t'(CoordMin)) begin
      res = CoordMin;
    end else begin
      res = v[CoordBits-1:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/vbb_axis.sv
// One output axis of the vertex transform: products, rounded sum, offset, clamp.
module vbb_axis (
  input  logic                clk_i,
  input  vbb_pkg::pipe_ctrl_t ctrl_i,
  input  vbb_pkg::in_t        vertex_i,
  input  vbb_pkg::row_t       row_i,
  input  vbb_pkg::coord_t     offset_i,
  input  logic                mode_i,
  output vbb_pkg::coord_t     coord_o
);

  localparam int ProdBits = vbb_pkg::ProdBits;
  localparam int AccBits  = vbb_pkg::AccBits;
  localparam int RndBits  = vbb_pkg::RndBits;
  localparam int SatBits  = vbb_pkg::SatBits;
  localparam int CoefBits = vbb_pkg::CoefBits;
  localparam int CoefFrac = vbb_pkg::CoefFrac;

  localparam logic signed [AccBits-1:0] RoundHalf = AccBits'(1) <<< (CoefFrac - 1);

  vbb_pkg::coord_t           vert    [3];
  vbb_pkg::coef_t            coef    [3];
  logic signed [ProdBits-1:0] prod_d [3];
  logic signed [ProdBits-1:0] prod_q [3];
  logic signed [AccBits-1:0]  acc;
  logic signed [RndBits-1:0]  rnd;
  vbb_pkg::wide_t             total;
  vbb_pkg::coord_t            coord_d;
  vbb_pkg::coord_t            coord_q;

  assign vert[0] = vertex_i.vertex_x;
  assign vert[1] = vertex_i.vertex_y;
  assign vert[2] = vertex_i.vertex_z;

  // Column k of the row sits in the k-th coefficient slice, column zero lowest.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      coef[k]   = row_i[k*CoefBits +: CoefBits];
      prod_d[k] = vert[k] * coef[k];
    end
  end

  // Product register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod_en) begin
      prod_q <= prod_d;
    end
  end

  // Exact sum, round half up to Q12.12, then the per-vertex offset in axis-aligned mode.
  always_comb begin
    acc = {{2{prod_q[0][ProdBits-1]}}, prod_q[0]}
        + {{2{prod_q[1][ProdBits-1]}}, prod_q[1]}
        + {{2{prod_q[2][ProdBits-1]}}, prod_q[2]}
        + RoundHalf;
    rnd   = acc[AccBits-1:CoefFrac];
    total = {{(SatBits-RndBits){rnd[RndBits-1]}}, rnd};
    if (mode_i == vbb_pkg::ModeAxisAligned) begin
      total = total + {{(SatBits-vbb_pkg::CoordBits){offset_i[vbb_pkg::CoordBits-1]}},
                       offset_i};
    end
    coord_d = vbb_pkg::sat_coord(total);
  end

  // Transformed coordinate register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.xform_en) begin
      coord_q <= coord_d;
    end
  end

  assign coord_o = coord_q;

endmodule

FILE: rtl/vertex_bounding_box.sv
// Top level of the vertex bounding box block: configuration, pipeline and extremes.

// The block takes one vertex per clock cycle and keeps the running bounding box
// of the transformed vertices. A vertex passes an input register, a product
// register (nine 24x16 multipliers), a transform register (rounded sum, offset
// and clamp per axis) and then updates the running minima and maxima; on a
// vertex marked last the finished extremes move to a box register and then to
// the output register with center and half widths. Throughput is one vertex
// per cycle while input ready is high; input ready drops only when the output
// register and the box register both hold results not yet taken and a further
// marked vertex has reached the extremes stage.
// Configuration writes take effect immediately and must be made while no vertex
// is in flight; they do not clear the running extremes.
module vertex_bounding_box (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vbb_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [vbb_pkg::CfgDataBits-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  vbb_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output vbb_pkg::out_t                       out_data_o
);

  `include "vertex_bounding_box_assert.svh"

  localparam int CoordBits = vbb_pkg::CoordBits;
  localparam int SatBits   = vbb_pkg::SatBits;

  // Configuration registers.
  logic            mode_q;
  vbb_pkg::row_t   row_q [3];
  vbb_pkg::coord_t off_q [3];

  // Pipeline control.
  logic in_valid_q, prod_valid_q, prod_last_q, x_valid_q, x_last_q;
  logic box_valid_q, out_valid_q;
  logic ready_in, ready_prod, ready_x, ready_box, ready_out;
  vbb_pkg::pipe_ctrl_t ctrl;

  // Payload.
  vbb_pkg::in_t    in_q;
  vbb_pkg::coord_t t_coord [3];
  vbb_pkg::coord_t low_q   [3];
  vbb_pkg::coord_t high_q  [3];
  vbb_pkg::coord_t low_d   [3];
  vbb_pkg::coord_t high_d  [3];
  vbb_pkg::coord_t box_lo_q [3];
  vbb_pkg::coord_t box_hi_q [3];
  vbb_pkg::coord_t ctr     [3];
  logic [vbb_pkg::HalfBits-1:0] half [3];
  vbb_pkg::out_t   out_d;
  vbb_pkg::out_t   out_q;
  logic            x_take;

  // Register writes; an index beyond the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= vbb_pkg::ModeAxisAligned;
      row_q[0] <= vbb_pkg::RowReset0;
      row_q[1] <= vbb_pkg::RowReset1;
      row_q[2] <= vbb_pkg::RowReset2;
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vbb_pkg::CfgMode: mode_q   <= cfg_data_i[0];
        vbb_pkg::CfgRow0: row_q[0] <= cfg_data_i;
        vbb_pkg::CfgRow1: row_q[1] <= cfg_data_i;
        vbb_pkg::CfgRow2: row_q[2] <= cfg_data_i;
        vbb_pkg::CfgOffX: off_q[0] <= cfg_data_i[CoordBits-1:0];
        vbb_pkg::CfgOffY: off_q[1] <= cfg_data_i[CoordBits-1:0];
        vbb_pkg::CfgOffZ: off_q[2] <= cfg_data_i[CoordBits-1:0];
        default: ;
      endcase
    end
  end

  // Stage readiness. Only marked vertices occupy the box and output stages.
  assign ready_out  = !out_valid_q || out_ready_i;
  assign ready_box  = !box_valid_q || ready_out;
  assign ready_x    = !x_valid_q || !x_last_q || ready_box;
  assign ready_prod = !prod_valid_q || ready_x;
  assign ready_in   = !in_valid_q || ready_prod;
  assign in_ready_o = ready_in;

  assign ctrl.prod_en  = in_valid_q && ready_prod;
  assign ctrl.xform_en = prod_valid_q && ready_x;
  assign x_take        = x_valid_q && ready_x;

  // Valid bits of the pipeline stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      prod_valid_q <= 1'b0;
      prod_last_q  <= 1'b0;
      x_valid_q    <= 1'b0;
      x_last_q     <= 1'b0;
      box_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (ready_in) begin
        in_valid_q <= in_valid_i;
      end
      if (ready_prod) begin
        prod_valid_q <= in_valid_q;
        prod_last_q  <= in_q.last_vertex;
      end
      if (ready_x) begin
        x_valid_q <= prod_valid_q;
        x_last_q  <= prod_last_q;
      end
      if (ready_box) begin
        box_valid_q <= x_valid_q && x_last_q;
      end
      if (ready_out) begin
        out_valid_q <= box_valid_q;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready_in) begin
      in_q <= in_data_i;
    end
  end

  // Transform, one unit per output axis.
  for (genvar g = 0; g < 3; g++) begin : g_axis
    vbb_axis u_axis (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .vertex_i (in_q),
      .row_i    (row_q[g]),
      .offset_i (off_q[g]),
      .mode_i   (mode_q),
      .coord_o  (t_coord[g])
    );
  end

  // Running extremes including the current vertex.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      low_d[k]  = (t_coord[k] < low_q[k])  ? t_coord[k] : low_q[k];
      high_d[k] = (t_coord[k] > high_q[k]) ? t_coord[k] : high_q[k];
    end
  end

  // Extremes update; a marked vertex hands the box on and restarts the search.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        low_q[k]  <= vbb_pkg::CoordMax;
        high_q[k] <= vbb_pkg::CoordMin;
      end
    end else if (x_take) begin
      for (int k = 0; k < 3; k++) begin
        low_q[k]  <= x_last_q ? vbb_pkg::CoordMax : low_d[k];
        high_q[k] <= x_last_q ? vbb_pkg::CoordMin : high_d[k];
      end
    end
  end

  // Box register with the final extremes of a model.
  always_ff @(posedge clk_i) begin
    if (x_take && x_last_q) begin
      box_lo_q <= low_d;
      box_hi_q <= high_d;
    end
  end

  // Center as floored midpoint, plus the offset in oriented mode; half widths.
  always_comb begin
    logic signed [CoordBits:0] sum;
    logic signed [CoordBits:0] diff;
    vbb_pkg::wide_t            c;
    for (int k = 0; k < 3; k++) begin
      sum  = {box_lo_q[k][CoordBits-1], box_lo_q[k]}
           + {box_hi_q[k][CoordBits-1], box_hi_q[k]};
      diff = {box_hi_q[k][CoordBits-1], box_hi_q[k]}
           - {box_lo_q[k][CoordBits-1], box_lo_q[k]};
      c    = {{(SatBits-CoordBits){sum[CoordBits]}}, sum[CoordBits:1]};
      if (mode_q == vbb_pkg::ModeOriented) begin
        c = c + {{(SatBits-CoordBits){off_q[k][CoordBits-1]}}, off_q[k]};
      end
      ctr[k]  = vbb_pkg::sat_coord(c);
      half[k] = diff[CoordBits-1:1];
    end
  end

  always_comb begin
    out_d.min_x    = box_lo_q[0];
    out_d.min_y    = box_lo_q[1];
    out_d.min_z    = box_lo_q[2];
    out_d.max_x    = box_hi_q[0];
    out_d.max_y    = box_hi_q[1];
    out_d.max_z    = box_hi_q[2];
    out_d.center_x = ctr[0];
    out_d.center_y = ctr[1];
    out_d.center_z = ctr[2];
    out_d.half_x   = half[0];
    out_d.half_y   = half[1];
    out_d.half_z   = half[2];
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (box_valid_q && ready_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A finished model leaves the search restarted: minimum on x and y, maximum on z.
  `VBB_ASSERT_NEXT(a_extremes_restart, x_take && x_last_q, low_q[0] == vbb_pkg::CoordMax && high_q[2] == vbb_pkg::CoordMin && low_q[1] == vbb_pkg::CoordMax, "extremes not cleared after last vertex")
  // A held box always covers at least one vertex.
  `VBB_ASSERT_SAME(a_box_ordered, box_valid_q, box_lo_q[0] <= box_hi_q[0] && box_lo_q[1] <= box_hi_q[1] && box_lo_q[2] <= box_hi_q[2], "box register holds an empty box")
  // The delivered center lies within the box on the x axis in axis-aligned mode.
  `VBB_ASSERT_SAME(a_center_inside, out_valid_q && mode_q == vbb_pkg::ModeAxisAligned, out_q.center_x >= out_q.min_x && out_q.center_x <= out_q.max_x, "center outside the box")

endmodule
